// ----- src/rct_pkg.sv -----
// Package for the min-cost route table: table sizing, entry layout, codes and
// id conversion helpers. Depends on nothing; imported by min_cost_route_table, rct_cmp and rct_chk.
`default_nettype none

package rct_pkg;

  localparam int MAX_ROUTES = 64;
  localparam int ID_BITS    = 8;
  localparam int COST_W     = 16;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);

  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_IMPROVED  = 3'd1,
    ST_KEPT      = 3'd2,
    ST_FULL      = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [ID_BITS-1:0] hop;
    logic [ID_BITS-1:0] dest;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  // Result of one pass through the shared compare unit.
  typedef struct packed {
    logic hit;    // entry destination equals the key
    logic lower;  // offered cost strictly below the stored cost
  } cmp_res_t;

  // Take an 8-bit id field in its low ID_BITS bits.
  function automatic logic [ID_BITS-1:0] id_from_byte(input logic [7:0] b);
    logic [ID_BITS+7:0] wide;
    wide = {{ID_BITS{1'b0}}, b};
    return wide[ID_BITS-1:0];
  endfunction

  // Widen or trim a stored id back onto an 8-bit field.
  function automatic logic [7:0] byte_from_id(input logic [ID_BITS-1:0] id);
    logic [ID_BITS+7:0] wide;
    wide = {8'h00, id};
    return wide[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/min_cost_route_table.sv -----
// Top level of the min-cost route table: scan sequencer, entry RAM, shared
// compare unit and output register. Depends on rct_pkg, rct_ram, rct_cmp.
//
//   channel  | direction | payload (low bit first)                 | handshake
//   ---------+-----------+-----------------------------------------+-------------------------
//   s_axis   | in        | tuser: operation; tdata: dest, next_hop, | tvalid/tready
//            |           | cost                                    |
//   m_axis   | out       | tuser: status; tdata: hop_out, cost_out | tvalid/tready
//   cfg      | in        | data: own_id                            | cfg_valid_i/cfg_ready_o
//
// Sequence: an operation is accepted in idle, then the sequencer walks the table
// one entry per cycle through the compare unit (one RAM read port), stopping
// at the first match or the last valid entry (1 to MAX_ROUTES entries scanned),
// and then returns to idle, where the next operation is accepted.
// Reset: the table holds only the self route (own_id, cost 0); no clearing pass.
// Stalls: a finished result waits in the output register; the scan holds on
// its last entry while that register is still occupied.
`default_nettype none

module min_cost_route_table
  import rct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,      // own_id
  // operation stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,    // [7:0] dest, [15:8] next_hop, [31:16] cost
  input  wire logic [0:0]  s_axis_tuser,    // [0] operation
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,    // [7:0] hop_out, [23:8] cost_out
  output logic [2:0]       m_axis_tuser     // [2:0] status
);

  // Sequencer state and the latched operation.
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ID_BITS-1:0] own_id_q;
  op_e                op_q;
  logic [ID_BITS-1:0] dest_q;
  logic [ID_BITS-1:0] hop_q;
  logic [COST_W-1:0]  cost_q;

  // Output register.
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [ID_BITS-1:0] out_hop_q, out_hop_d;
  logic [COST_W-1:0]  out_cost_q, out_cost_d;

  // Datapath nets.
  route_entry_t       ram_rdata;
  route_entry_t       ram_wdata;
  route_entry_t       self_entry;
  route_entry_t       cur_entry;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  cmp_res_t           cmp;
  logic [CNT_W-1:0]   idx_next;
  logic               in_xfer;
  logic               cfg_xfer;
  logic               out_free;
  logic               scan_done;
  logic               finish;
  logic               table_full;

  assign cfg_ready_o   = (state_q == S_IDLE);
  // Config wins when both arrive together, so an operation always sees the new id.
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_xfer      = cfg_valid_i && cfg_ready_o;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Entry 0 is the self route; cost 0 can never be lowered, so it lives in a register.
  assign self_entry.dest = own_id_q;
  assign self_entry.hop  = own_id_q;
  assign self_entry.cost = '0;
  assign cur_entry       = (idx_q == '0) ? self_entry : ram_rdata;

  rct_cmp u_cmp (
    .entry_i (cur_entry),
    .key_i   (dest_q),
    .cost_i  (cost_q),
    .res_o   (cmp)
  );

  assign idx_next   = CNT_W'(idx_q) + CNT_W'(1);
  assign scan_done  = cmp.hit || (idx_next == count_q);
  assign out_free   = !out_valid_q || m_axis_tready;
  assign finish     = (state_q == S_SCAN) && scan_done && out_free;
  assign table_full = (count_q == CNT_W'(MAX_ROUTES));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Scan index, table writes and result.
  always_comb begin
    idx_d        = idx_q;
    count_d      = count_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '{cost: cost_q, hop: hop_q, dest: dest_q};
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_hop_d    = out_hop_q;
    out_cost_d   = out_cost_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d = '0;
        end
        if (cfg_xfer) begin
          count_d = CNT_W'(1);
        end
      end
      S_SCAN: begin
        if (!scan_done) begin
          idx_d = idx_next[IDX_W-1:0];
        end
        if (finish) begin
          out_valid_d = 1'b1;
          if (op_q == OP_LOOKUP) begin
            if (cmp.hit) begin
              out_status_d = ST_FOUND;
              out_hop_d    = cur_entry.hop;
              out_cost_d   = cur_entry.cost;
            end else begin
              out_status_d = ST_NOT_FOUND;
              out_hop_d    = '0;
              out_cost_d   = '0;
            end
          end else if (cmp.hit) begin
            if (cmp.lower) begin
              // improve in place
              ram_we       = 1'b1;
              out_status_d = ST_IMPROVED;
              out_hop_d    = hop_q;
              out_cost_d   = cost_q;
            end else begin
              out_status_d = ST_KEPT;
              out_hop_d    = cur_entry.hop;
              out_cost_d   = cur_entry.cost;
            end
          end else if (!table_full) begin
            // append at the first free slot
            ram_we       = 1'b1;
            ram_waddr    = count_q[IDX_W-1:0];
            count_d      = count_q + CNT_W'(1);
            out_status_d = ST_INSERTED;
            out_hop_d    = hop_q;
            out_cost_d   = cost_q;
          end else begin
            out_status_d = ST_FULL;
            out_hop_d    = '0;
            out_cost_d   = '0;
          end
        end
      end
      default: ;
    endcase
  end

  rct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ROUTES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (idx_d),       // data for idx_d is ready when it becomes idx_q
    .rd_data_o (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= CNT_W'(1);
      own_id_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_xfer) begin
        own_id_q <= id_from_byte(cfg_data_i);
      end
    end
  end

  // Payload registers: latch the operation, hold the result.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= op_e'(s_axis_tuser[0]);
      dest_q <= id_from_byte(s_axis_tdata[7:0]);
      hop_q  <= id_from_byte(s_axis_tdata[15:8]);
      cost_q <= s_axis_tdata[31:16];
    end
    out_status_q <= out_status_d;
    out_hop_q    <= out_hop_d;
    out_cost_q   <= out_cost_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_cost_q, byte_from_id(out_hop_q)};

endmodule

`default_nettype wire

// ----- src/rct_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the route entries of the table.
`default_nettype none

module rct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr_i,
  input  wire logic [WIDTH-1:0]                 wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr_i,
  output logic      [WIDTH-1:0]                 rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// ----- src/rct_cmp.sv -----
// Shared compare unit: matches one table entry against the search key and
// the offered cost. Depends on rct_pkg.
`default_nettype none

module rct_cmp
  import rct_pkg::*;
(
  input  wire route_entry_t       entry_i,
  input  wire logic [ID_BITS-1:0] key_i,
  input  wire logic [COST_W-1:0]  cost_i,
  output cmp_res_t                res_o
);

  assign res_o.hit   = (entry_i.dest == key_i);
  assign res_o.lower = (cost_i < entry_i.cost);

endmodule

`default_nettype wire

// ----- src/rct_chk.sv -----
// Port-level checker for the min-cost route table, bound to the top level.
// Depends on rct_pkg for the status codes.
`default_nettype none

module rct_chk
  import rct_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [7:0]  cfg_data_i,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic [0:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A held result keeps its payload until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The block is busy in the cycle after taking an operation.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready_o)
    else $error("operation accepted back to back");

  // A config write and an operation never complete in the same cycle.
  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_valid_i && cfg_ready_o && s_axis_tvalid && s_axis_tready))
    else $error("config and operation accepted together");

  // Full and not-found results carry no route.
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOT_FOUND)
      |-> m_axis_tdata == '0)
    else $error("absent route reported with nonzero payload");

endmodule

bind min_cost_route_table rct_chk u_rct_chk (.*);

`default_nettype wire
